### design/ct_pkg.sv
package ct_pkg;

  localparam int KEY_MAX    = 8;
  localparam int ROWS_MAX   = 8;
  localparam int CAPACITY   = KEY_MAX * ROWS_MAX;
  localparam int CHAR_W     = 16;
  localparam int KEY_IDX_W  = 3;
  localparam int KLEN_W     = 4;
  localparam int ROWS_W     = 4;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 16'h0030;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 2'd0,
    CFG_KEY_LOW    = 2'd1,
    CFG_KEY_HIGH   = 2'd2,
    CFG_DECODE     = 2'd3
  } cfg_reg_e;

  // Picks keyword character idx out of the two packed key registers.
  function automatic logic [CHAR_W-1:0] key_char(input logic [CFG_DATA_W-1:0] lo,
                                                 input logic [CFG_DATA_W-1:0] hi,
                                                 input logic [KEY_IDX_W-1:0]  idx);
    logic [5:0] base;
    base = {idx[1:0], 4'b0000};
    if (idx[2]) begin
      return hi[base +: CHAR_W];
    end
    return lo[base +: CHAR_W];
  endfunction

  // Column count: zero acts as one, anything above the maximum as the maximum.
  function automatic logic [KLEN_W-1:0] cols_clamp(input logic [KLEN_W-1:0] klen);
    if (klen == '0) begin
      return KLEN_W'(1);
    end
    if (klen > KLEN_W'(KEY_MAX)) begin
      return KLEN_W'(KEY_MAX);
    end
    return klen;
  endfunction

endpackage

### design/ct_in_if.sv
interface ct_in_if;
  import ct_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

### design/ct_out_if.sv
interface ct_out_if;
  import ct_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              overflow;

  modport source (output valid, output out_char, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input overflow,
                  output ready);
endinterface

### design/ct_ram.sv
module ct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/columnar_transposition_top.sv
// Channel | Direction | Payload                          | Handshake
// req_i   | in        | in_char[15:0], in_last           | valid / ready
// res_o   | out       | out_char[15:0], out_last, ovf    | valid / ready
// cfg     | in        | cfg_idx_i[1:0], cfg_data_i[63:0] | cfg_we_i, no back-pressure
//
// Requests are accepted only while the block is in its load state. After the
// request that carries the last mark, ranking runs on one shared comparator,
// the row count runs on one adder, and then each result goes through the
// shared multiply-add for its address and then the registered grid memory
// read, and it waits out any stall on the result side.
// Reset is asynchronous and active low; the grid memory is not cleared.
module columnar_transposition_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ct_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ct_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  ct_in_if.sink                              req_i,
  ct_out_if.source                           res_o
);
  import ct_pkg::*;

  // One-hot sequencer: load requests, rank the key, count rows, then emit.
  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RANK = 5'b00010,
    S_ROWS = 5'b00100,
    S_ADDR = 5'b01000,
    S_WAIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [KLEN_W-1:0]     key_len_q;
  logic [CFG_DATA_W-1:0] key_lo_q, key_hi_q;
  logic                  decode_q;

  // Message bookkeeping.
  logic [CNT_W-1:0] count_q;
  logic             drop_q;

  // Ranking state: i is the column being ranked, j the one it is compared with.
  logic [KEY_IDX_W-1:0] i_q, j_q, cnt_q;
  logic [KEY_IDX_W-1:0] rank_q  [KEY_MAX];
  logic [KEY_IDX_W-1:0] order_q [KEY_MAX];

  // Row count and emit counters.
  logic [CNT_W-1:0]     acc_q, total_q, pos_q;
  logic [ROWS_W-1:0]    rows_q;
  logic [KEY_IDX_W-1:0] inner_q, outer_q;
  logic                 pad_q;

  // Combinational helpers.
  logic [KLEN_W-1:0] k;
  logic [CNT_W-1:0]  cap, n, acc_d, addr, prod;
  logic              in_fire, out_fire, store_ok, is_last;
  logic [CHAR_W-1:0] ci, cj, rdata;
  logic              hit, j_end, i_end, inner_end;
  logic [KEY_IDX_W-1:0] cnt_nx, mul_a, mul_c;
  logic [ROWS_W-1:0]    mul_b, inner_lim;

  assign k   = cols_clamp(key_len_q);
  assign cap = CNT_W'(k) * CNT_W'(ROWS_MAX);
  // The key length may have shrunk mid message, so the held count is clamped.
  assign n   = (count_q > cap) ? cap : count_q;

  assign req_i.ready = (state_q == S_LOAD);
  assign in_fire     = req_i.valid && req_i.ready;
  assign store_ok    = (count_q < cap);

  assign res_o.valid = (state_q == S_WAIT);
  assign out_fire    = res_o.valid && res_o.ready;
  assign is_last     = ((pos_q + CNT_W'(1)) == total_q);

  // Shared comparator for ranking. Ties break toward the earlier column.
  assign ci     = key_char(key_lo_q, key_hi_q, i_q);
  assign cj     = key_char(key_lo_q, key_hi_q, j_q);
  assign hit    = (cj < ci) || ((j_q < i_q) && (cj == ci));
  assign cnt_nx = cnt_q + KEY_IDX_W'(hit);
  assign j_end  = (KLEN_W'(j_q) == (k - KLEN_W'(1)));
  assign i_end  = (KLEN_W'(i_q) == (k - KLEN_W'(1)));

  assign acc_d = acc_q + CNT_W'(k);

  // Shared multiply-add for the grid address. Encode walks ranked columns
  // top to bottom and reads cell row*k+col. Decode walks rows left to right
  // and reads the source character rank(col)*rows+row.
  always_comb begin
    if (decode_q) begin
      mul_a     = rank_q[inner_q];
      mul_b     = rows_q;
      mul_c     = outer_q;
      inner_lim = k;
    end else begin
      mul_a     = inner_q;
      mul_b     = k;
      mul_c     = order_q[outer_q];
      inner_lim = rows_q;
    end
  end

  assign prod      = CNT_W'(mul_a) * CNT_W'(mul_b);
  assign addr      = prod + CNT_W'(mul_c);
  assign inner_end = ((ROWS_W'(inner_q) + ROWS_W'(1)) == inner_lim);

  ct_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (in_fire && store_ok),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (req_i.in_char),
    .re_i    (state_q == S_ADDR),
    .raddr_i (addr[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // Cells past the n-th character come out as the pad.
  assign res_o.out_char = pad_q ? PAD_CHAR : rdata;
  assign res_o.out_last = is_last;
  assign res_o.overflow = drop_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KLEN_W'(1);
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      decode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LENGTH: key_len_q <= cfg_data_i[KLEN_W-1:0];
        CFG_KEY_LOW:    key_lo_q  <= cfg_data_i;
        CFG_KEY_HIGH:   key_hi_q  <= cfg_data_i;
        CFG_DECODE:     decode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (in_fire && req_i.in_last) state_d = S_RANK;
      S_RANK: if (j_end && i_end) state_d = S_ROWS;
      S_ROWS: if (acc_d >= n) state_d = S_ADDR;
      S_ADDR: state_d = S_WAIT;
      S_WAIT: begin
        if (out_fire) begin
          state_d = is_last ? S_LOAD : S_ADDR;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      rows_q  <= '0;
      total_q <= '0;
      pos_q   <= '0;
      inner_q <= '0;
      outer_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_fire) begin
            if (store_ok) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              drop_q <= 1'b1;
            end
            i_q   <= '0;
            j_q   <= '0;
            cnt_q <= '0;
          end
        end
        S_RANK: begin
          if (j_end) begin
            j_q   <= '0;
            cnt_q <= '0;
            i_q   <= i_q + KEY_IDX_W'(1);
          end else begin
            j_q   <= j_q + KEY_IDX_W'(1);
            cnt_q <= cnt_nx;
          end
          acc_q  <= '0;
          rows_q <= '0;
        end
        S_ROWS: begin
          acc_q  <= acc_d;
          rows_q <= rows_q + ROWS_W'(1);
          total_q <= decode_q ? n : acc_d;
          pos_q   <= '0;
          inner_q <= '0;
          outer_q <= '0;
        end
        S_WAIT: begin
          if (out_fire) begin
            if (is_last) begin
              count_q <= '0;
              drop_q  <= 1'b0;
            end else begin
              pos_q <= pos_q + CNT_W'(1);
              if (inner_end) begin
                inner_q <= '0;
                outer_q <= outer_q + KEY_IDX_W'(1);
              end else begin
                inner_q <= inner_q + KEY_IDX_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Rank tables and pad flag carry no reset; they are rebuilt for every message.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_RANK) && j_end) begin
      rank_q[i_q]     <= cnt_nx;
      order_q[cnt_nx] <= i_q;
    end
    if (state_q == S_ADDR) begin
      pad_q <= (addr >= n);
    end
  end

`ifndef SYNTHESIS
  // The block never takes a request while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && res_o.valid))
    else $error("request accepted while a result is pending");

  // The character count never passes the grid capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("character count beyond capacity");

  // A result position always lies inside the message total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (pos_q < total_q))
    else $error("result position past total");

  // Taking the final result clears the message and reopens the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && res_o.out_last) |=> (req_i.ready && (count_q == '0) && !drop_q))
    else $error("message not closed after final result");

  // The request with the last mark starts ranking in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_i.in_last) |=> (state_q == S_RANK))
    else $error("ranking did not start after last request");
`endif

endmodule
